// File: src/hexdump_text_to_binary_top_assert.svh
// Assertion macros for the hex-dump parser top level.
// Used by hexdump_text_to_binary_top only; expects clk and rst_n in scope.
`ifndef HEXDUMP_TEXT_TO_BINARY_TOP_ASSERT_SVH
`define HEXDUMP_TEXT_TO_BINARY_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HDTB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hdtb assertion failed");

// Next-cycle implication, disabled during reset
`define HDTB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hdtb assertion failed");

`endif

// File: src/hdtb_pkg.sv
// Shared types, constants and the hex digit decoder for the hex-dump parser.
// No dependencies.
package hdtb_pkg;

    // Fixed field widths
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 5;
    localparam int COLS_W     = 9;
    localparam int BASE_W     = 32;
    localparam int OUT_ADDR_W = 32;
    localparam int DATA_W     = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLAIN_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 2'd2;

    // Register reset values
    localparam logic [COLS_W-1:0] COLUMNS_RESET = 9'd16;

    // Characters of interest
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] ALPHA_BIAS = 8'd10;

    // Digit code for "not a hex digit"
    localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // One classified character
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               is_cr;
        logic               is_nl;
    } item_t;

    // Queue status toward the front
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Configuration registers
    typedef struct packed {
        logic [COLS_W-1:0] columns;
        logic              plain_mode;
        logic [BASE_W-1:0] base_offset;
    } cfg_t;

    // One result beat
    typedef struct packed {
        logic                  error;
        logic [DATA_W-1:0]     write_data;
        logic [OUT_ADDR_W-1:0] write_address;
    } result_t;

    // ASCII hex digit to 0..15, or DIGIT_NONE
    function automatic logic [DIGIT_W-1:0] hex_value(input logic [CHAR_W-1:0] ch);
        logic [CHAR_W-1:0] v;
        v = CHAR_W'(0);
        if (ch >= CHAR_0 && ch <= CHAR_9)
        begin
            v = ch - CHAR_0;
            return DIGIT_W'(v);
        end
        if (ch >= CHAR_LA && ch <= CHAR_LF)
        begin
            v = ch - CHAR_LA + ALPHA_BIAS;
            return DIGIT_W'(v);
        end
        if (ch >= CHAR_UA && ch <= CHAR_UF)
        begin
            v = ch - CHAR_UA + ALPHA_BIAS;
            return DIGIT_W'(v);
        end
        return DIGIT_NONE;
    endfunction

endpackage

// File: src/hdtb_front.sv
// Front end: accepts text beats, classifies each character and pushes it
// into the queue. Depends on hdtb_pkg.
module hdtb_front
(
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [hdtb_pkg::CHAR_W-1:0]   s_tdata,   // [7:0] character
    input  hdtb_pkg::q_stat_t             q_stat,
    output logic                          push,
    output hdtb_pkg::item_t               push_item
);

    // Take a beat whenever the queue has room
    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && !q_stat.full;

    // Classification
    always_comb
    begin
        push_item.digit = hdtb_pkg::hex_value(s_tdata);
        push_item.is_cr = (s_tdata == hdtb_pkg::CHAR_CR);
        push_item.is_nl = (s_tdata == hdtb_pkg::CHAR_NL);
    end

endmodule

// File: src/hdtb_queue.sv
// Two-entry queue of classified characters between front and back.
// Depends on hdtb_pkg.
module hdtb_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hdtb_pkg::item_t   push_item,
    input  logic              pop,
    output logic              head_valid,
    output hdtb_pkg::item_t   head_item,
    output hdtb_pkg::q_stat_t q_stat
);

    hdtb_pkg::item_t                  entry_reg [hdtb_pkg::QUEUE_DEPTH];
    logic [hdtb_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [hdtb_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [hdtb_pkg::QCNT_W-1:0]      count_reg;
    logic [hdtb_pkg::QCNT_W-1:0]      count_next;
    logic                             do_push;
    logic                             do_pop;

    assign q_stat.full  = (count_reg == hdtb_pkg::QCNT_W'(hdtb_pkg::QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head_valid   = !q_stat.empty;
    assign head_item    = entry_reg[rd_ptr_reg];

    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && !q_stat.empty;

    // Occupancy
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: src/hdtb_back.sv
// Back end: line parser state, byte assembly, address check and the output
// register. Depends on hdtb_pkg.
module hdtb_back
#(
    parameter int MAX_COLUMNS   = 256,
    parameter int ADDRESS_WIDTH = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  hdtb_pkg::cfg_t                       cfg,
    input  logic                                 head_valid,
    input  hdtb_pkg::item_t                      head_item,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [hdtb_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int CC_W  = $clog2(MAX_COLUMNS + 1);
    localparam int CMP_W = (CC_W > hdtb_pkg::COLS_W) ? CC_W : hdtb_pkg::COLS_W;
    localparam int NEG_W = (ADDRESS_WIDTH > hdtb_pkg::BASE_W) ? ADDRESS_WIDTH
                                                               : hdtb_pkg::BASE_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_COLUMNS);
    localparam logic [CC_W-1:0]  CC_FULL = CC_W'(MAX_COLUMNS);
    localparam int PAD_W = hdtb_pkg::OUT_TDATA_W - $bits(hdtb_pkg::result_t);

    // Parser state
    logic [hdtb_pkg::DIGIT_W-1:0] last_digit_reg, last_digit_next;
    logic [hdtb_pkg::DIGIT_W-1:0] prev_digit_reg, prev_digit_next;
    logic [hdtb_pkg::DIGIT_W-1:0] old_digit_reg,  old_digit_next;
    logic                         skip_reg,       skip_next;
    logic [CC_W-1:0]              col_count_reg,  col_count_next;
    logic [ADDRESS_WIDTH-1:0]     line_offset_reg, line_offset_next;
    logic                         discard_reg,    discard_next;
    logic                         halted_reg,     halted_next;

    // Output stage
    logic                         out_valid_reg,  out_valid_next;
    hdtb_pkg::result_t            out_data_reg,   out_data_next;

    // Helpers
    logic [CMP_W-1:0]             cols_raw;
    logic [CMP_W-1:0]             eff_cols;
    logic                         line_full;
    logic [CC_W-1:0]              cc_work;
    logic [hdtb_pkg::BASE_W-1:0]  neg_mag;
    logic                         addr_negative;
    logic                         emit;
    hdtb_pkg::result_t            emit_data;

    assign pop      = head_valid && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_data_reg};

    // Column limit, clamped to 1..MAX_COLUMNS
    always_comb
    begin
        cols_raw = CMP_W'(cfg.columns);
        if (cols_raw == '0)
        begin
            eff_cols = CMP_W'(1);
        end
        else if (cols_raw > MAX_CMP)
        begin
            eff_cols = MAX_CMP;
        end
        else
        begin
            eff_cols = cols_raw;
        end
    end

    assign line_full = (CMP_W'(col_count_reg) >= eff_cols);

    // Target below zero: base negative and its magnitude exceeds the offset
    assign neg_mag       = ~cfg.base_offset + 1'b1;
    assign addr_negative = cfg.base_offset[hdtb_pkg::BASE_W-1]
                           && (NEG_W'(line_offset_reg) < NEG_W'(neg_mag));

    // Per-character step
    always_comb
    begin
        last_digit_next  = last_digit_reg;
        prev_digit_next  = prev_digit_reg;
        old_digit_next   = old_digit_reg;
        skip_next        = skip_reg;
        col_count_next   = col_count_reg;
        line_offset_next = line_offset_reg;
        discard_next     = discard_reg;
        halted_next      = halted_reg;
        cc_work          = col_count_reg;
        emit             = 1'b0;
        emit_data        = '0;

        if (pop && !halted_reg)
        begin
            if (discard_reg)
            begin
                if (head_item.is_nl)
                begin
                    discard_next = 1'b0;
                end
            end
            else if (!head_item.is_cr)
            begin
                old_digit_next  = prev_digit_reg;
                prev_digit_next = last_digit_reg;
                last_digit_next = head_item.digit;
                if (!(head_item.digit[4] && skip_reg))
                begin
                    skip_next = 1'b0;
                    if (line_full && !cfg.plain_mode)
                    begin
                        // Offset field
                        if (head_item.digit[4])
                        begin
                            col_count_next = '0;
                        end
                        else
                        begin
                            line_offset_next = {line_offset_reg[ADDRESS_WIDTH-5:0],
                                                head_item.digit[3:0]};
                        end
                    end
                    else
                    begin
                        if (line_full)
                        begin
                            cc_work        = '0;
                            col_count_next = '0;
                        end
                        if (addr_negative)
                        begin
                            halted_next     = 1'b1;
                            emit            = 1'b1;
                            emit_data.error = 1'b1;
                        end
                        else if (!last_digit_reg[4] && !head_item.digit[4])
                        begin
                            // Two digits in a row: one byte
                            emit                    = 1'b1;
                            emit_data.write_address =
                                hdtb_pkg::OUT_ADDR_W'(line_offset_reg) + cfg.base_offset;
                            emit_data.write_data    = {last_digit_reg[3:0],
                                                       head_item.digit[3:0]};
                            line_offset_next        = line_offset_reg + 1'b1;
                            last_digit_next         = hdtb_pkg::DIGIT_NONE;
                            col_count_next          = cc_work + 1'b1;
                            if (CMP_W'(cc_work + 1'b1) >= eff_cols)
                            begin
                                if (!cfg.plain_mode)
                                begin
                                    line_offset_next = '0;
                                end
                                discard_next = 1'b1;
                                skip_next    = 1'b1;
                            end
                        end
                        else if (head_item.digit[4] && last_digit_reg[4]
                                 && prev_digit_reg[4])
                        begin
                            // Three non-hex characters: end of line
                            if (!cfg.plain_mode)
                            begin
                                line_offset_next = '0;
                            end
                            discard_next = 1'b1;
                            skip_next    = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit_data;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_digit_reg  <= hdtb_pkg::DIGIT_NONE;
            prev_digit_reg  <= '0;
            old_digit_reg   <= hdtb_pkg::DIGIT_NONE;
            skip_reg        <= 1'b1;
            col_count_reg   <= CC_FULL;
            line_offset_reg <= '0;
            discard_reg     <= 1'b0;
            halted_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            last_digit_reg  <= last_digit_next;
            prev_digit_reg  <= prev_digit_next;
            old_digit_reg   <= old_digit_next;
            skip_reg        <= skip_next;
            col_count_reg   <= col_count_next;
            line_offset_reg <= line_offset_next;
            discard_reg     <= discard_next;
            halted_reg      <= halted_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

// File: src/hexdump_text_to_binary_top.sv
// Top level of the hex-dump text to binary parser: configuration registers,
// front end, queue and back end. Depends on hdtb_pkg, hdtb_front,
// hdtb_queue, hdtb_back and hexdump_text_to_binary_top_assert.svh.
//
//   Channel | Ports                      | Beat contents (low bit up)
//   --------+----------------------------+-----------------------------------
//   text in | s_tvalid s_tready s_tdata  | character[7:0]
//   bytes   | m_tvalid m_tready m_tdata  | write_address[31:0] write_data[39:32]
//           |                            | error[40], zero pad [47:41]
//   config  | cfg_we cfg_index cfg_data  | columns / plain_mode / base_offset
//
// One character per cycle sustained while the byte side keeps up; the character
// that completes a byte is registered in the queue, then the back end fills the
// output register from it. The back end's parse step with its 32-bit add and
// compare sets the rate. While a byte beat waits unaccepted the back end holds;
// the two-entry queue then fills and s_tready drops only while it is full.
// Reset is asynchronous and needs no clearing pass.
module hexdump_text_to_binary_top
#(
    parameter int MAX_COLUMNS   = 256,
    parameter int ADDRESS_WIDTH = 32
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [hdtb_pkg::CHAR_W-1:0]           s_tdata,   // [7:0] character
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [31:0] write_address, [39:32] write_data, [40] error, [47:41] zero
    output logic [hdtb_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                  cfg_we,
    input  logic [hdtb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [hdtb_pkg::CFG_DATA_W-1:0]       cfg_data
);

    hdtb_pkg::cfg_t    cfg_reg;
    hdtb_pkg::q_stat_t q_stat;
    hdtb_pkg::item_t   push_item;
    hdtb_pkg::item_t   head_item;
    logic              push;
    logic              pop;
    logic              head_valid;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.columns     <= hdtb_pkg::COLUMNS_RESET;
            cfg_reg.plain_mode  <= 1'b0;
            cfg_reg.base_offset <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hdtb_pkg::REG_COLUMNS:
                begin
                    cfg_reg.columns <= cfg_data[hdtb_pkg::COLS_W-1:0];
                end
                hdtb_pkg::REG_PLAIN_MODE:
                begin
                    cfg_reg.plain_mode <= cfg_data[0];
                end
                hdtb_pkg::REG_BASE_OFFSET:
                begin
                    cfg_reg.base_offset <= cfg_data[hdtb_pkg::BASE_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    hdtb_front u_front
    (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_stat    (q_stat),
        .push      (push),
        .push_item (push_item)
    );

    hdtb_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .q_stat     (q_stat)
    );

    hdtb_back
    #(
        .MAX_COLUMNS   (MAX_COLUMNS),
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // Checks
`include "hexdump_text_to_binary_top_assert.svh"

    // An error beat carries zero address and data
    `HDTB_ASSERT_NOW(a_err_beat_zero, m_tvalid && m_tdata[40], m_tdata[39:0] == 40'd0)
    // Nothing follows an error beat once it is taken
    `HDTB_ASSERT_NEXT(a_halt_after_err, m_tvalid && m_tready && m_tdata[40], !m_tvalid)
    // Queue status is consistent
    `HDTB_ASSERT_NOW(a_queue_sane, 1'b1, !(q_stat.full && q_stat.empty))

endmodule

// File: tb/sv/hexdump_text_to_binary_checker.sv
// Checker for the hex-dump parser: watches the text, byte and config channels,
// predicts every byte beat and compares it field by field. Depends on hdtb_pkg.
module hexdump_text_to_binary_checker
    import hdtb_pkg::*;
#(
    parameter int MAX_COLUMNS = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [CHAR_W-1:0]      s_tdata,     // [7:0] character
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] write_address, [39:32] write_data, [40] error, [47:41] zero
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     mismatches,
    output int                     outstanding
);

    // Shadow of the configuration registers
    logic [COLS_W-1:0] cur_columns;
    logic              cur_plain;
    logic [BASE_W-1:0] cur_base;

    // Parser state as seen from outside
    logic [DIGIT_W-1:0] newest_dig;
    logic [DIGIT_W-1:0] middle_dig;
    logic [DIGIT_W-1:0] third_dig;
    bit                 skipping_lead;
    int                 bytes_on_line;
    logic [31:0]        line_addr;
    bit                 dropping_line;
    bit                 stopped;

    result_t expected_writes[$];

    task automatic flag_mismatch(input string what, input logic [47:0] got,
                                 input logic [47:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] ch);
        if (ch >= CHAR_0 && ch <= CHAR_9)
            return DIGIT_W'(ch - CHAR_0);
        else if (ch >= CHAR_UA && ch <= CHAR_UF)
            return DIGIT_W'(ch - CHAR_UA + 8'd10);
        else if (ch >= CHAR_LA && ch <= CHAR_LF)
            return DIGIT_W'(ch - CHAR_LA + 8'd10);
        return DIGIT_NONE;
    endfunction

    function automatic void close_line();
        if (!cur_plain)
            line_addr = '0;
        dropping_line = 1'b1;
        skipping_lead = 1'b1;
    endfunction

    function automatic void reset_parser();
        cur_columns   = COLUMNS_RESET;
        cur_plain     = 1'b0;
        cur_base      = '0;
        newest_dig    = DIGIT_NONE;
        middle_dig    = '0;
        third_dig     = DIGIT_NONE;
        skipping_lead = 1'b1;
        bytes_on_line = MAX_COLUMNS;
        line_addr     = '0;
        dropping_line = 1'b0;
        stopped       = 1'b0;
    endfunction

    // One character through the parser; returns 1 when a write or error beat is due
    function automatic bit parse_char(input logic [CHAR_W-1:0] ch, output result_t r);
        int     lim;
        longint target;
        r = '0;
        if (cur_columns == 0)
            lim = 1;
        else if (cur_columns > MAX_COLUMNS)
            lim = MAX_COLUMNS;
        else
            lim = int'(cur_columns);

        if (stopped)
            return 1'b0;
        if (dropping_line)
        begin
            if (ch == CHAR_NL)
                dropping_line = 1'b0;
            return 1'b0;
        end
        if (ch == CHAR_CR)
            return 1'b0;

        third_dig  = middle_dig;
        middle_dig = newest_dig;
        newest_dig = digit_of(ch);
        if (newest_dig == DIGIT_NONE && skipping_lead)
            return 1'b0;
        skipping_lead = 1'b0;

        // line full: offset field in offset mode, new line in plain mode
        if (bytes_on_line >= lim)
        begin
            if (!cur_plain)
            begin
                if (newest_dig == DIGIT_NONE)
                begin
                    bytes_on_line = 0;
                    return 1'b0;
                end
                line_addr = {line_addr[27:0], newest_dig[3:0]};
                return 1'b0;
            end
            bytes_on_line = 0;
        end

        // target below zero halts the block
        target = longint'($signed(cur_base)) + longint'({32'b0, line_addr});
        if (target < 0)
        begin
            stopped = 1'b1;
            r.error = 1'b1;
            return 1'b1;
        end

        if (middle_dig != DIGIT_NONE && newest_dig != DIGIT_NONE)
        begin
            r.write_address = line_addr + cur_base;
            r.write_data    = {middle_dig[3:0], newest_dig[3:0]};
            line_addr       = line_addr + 32'd1;
            newest_dig      = DIGIT_NONE;
            bytes_on_line++;
            if (bytes_on_line >= lim)
                close_line();
            return 1'b1;
        end
        // three non-hex characters in a row end the line
        if (newest_dig == DIGIT_NONE && middle_dig == DIGIT_NONE && third_dig == DIGIT_NONE)
            close_line();
        return 1'b0;
    endfunction

    // Compare, predict and shadow the registers on every edge
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            reset_parser();
            expected_writes.delete();
            mismatches = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(result_t)-1:0];
                if (expected_writes.size() == 0)
                    flag_mismatch("beat with nothing expected", m_tdata, '0);
                else
                begin
                    want = expected_writes.pop_front();
                    if (got.write_address !== want.write_address)
                        flag_mismatch("write_address", 48'(got.write_address),
                                      48'(want.write_address));
                    if (got.write_data !== want.write_data)
                        flag_mismatch("write_data", 48'(got.write_data),
                                      48'(want.write_data));
                    if (got.error !== want.error)
                        flag_mismatch("error", 48'(got.error), 48'(want.error));
                    if (m_tdata[OUT_TDATA_W-1:$bits(result_t)] !== '0)
                        flag_mismatch("pad bits",
                                      48'(m_tdata[OUT_TDATA_W-1:$bits(result_t)]), '0);
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (parse_char(s_tdata, want))
                    expected_writes.push_back(want);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_COLUMNS:     cur_columns = cfg_data[COLS_W-1:0];
                    REG_PLAIN_MODE:  cur_plain   = cfg_data[0];
                    REG_BASE_OFFSET: cur_base    = cfg_data[BASE_W-1:0];
                    default:         ;
                endcase
            end
        end
        outstanding = expected_writes.size();
    end

endmodule

// File: tb/sv/hexdump_text_to_binary_top_test.sv
// Testbench top for the hex-dump parser: clock, reset, text stimulus, byte
// receiver, register writes, watchdog and verdict. Depends on hdtb_pkg,
// hexdump_text_to_binary_top and hexdump_text_to_binary_checker.
module hexdump_text_to_binary_top_test;
    import hdtb_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_PAD   = 8;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [CHAR_W-1:0]      s_tdata   = '0;     // [7:0] character
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [31:0] write_address, [39:32] write_data, [40] error, [47:41] zero
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int mismatches;
    int outstanding;

    bit idle_enable  = 1'b1;
    bit hold_pending = 1'b0;

    logic [CHAR_W-1:0] text_q[$];

    hexdump_text_to_binary_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hexdump_text_to_binary_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: too long without any beat ends the run
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("hexdump_text_to_binary_top_test: done, errors");
        $finish;
    end

    // Byte receiver: random ready bursts, one long hold-off on request
    initial
    begin : receiver
        @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (idle_enable && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // One character beat, with an optional idle burst ahead of it
    task automatic send_char(input logic [CHAR_W-1:0] ch);
        if (idle_enable && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_text();
        while (text_q.size() > 0)
            send_char(text_q.pop_front());
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Stop offering, wait for every expected beat, then let the pipe empty
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return CHAR_0 + v;
        else if ($urandom_range(0, 1))
            return CHAR_UA + (v - 4'd10);
        return CHAR_LA + (v - 4'd10);
    endfunction

    task automatic queue_string(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic queue_noise(input int n);
        repeat (n) text_q.push_back(CHAR_W'($urandom_range(0, 255)));
    endtask

    // Offset field, colon, hex pairs, optional text column, line end
    task automatic queue_offset_line(input int n_bytes);
        repeat ($urandom_range(1, 8)) text_q.push_back(hex_char(4'($urandom_range(0, 15))));
        text_q.push_back(CH_COLON);
        repeat (n_bytes)
        begin
            if ($urandom_range(0, 1))
                text_q.push_back(CH_SPACE);
            if ($urandom_range(0, 11) == 0)
                text_q.push_back(CHAR_W'($urandom_range(0, 255)));
            text_q.push_back(hex_char(4'($urandom_range(0, 15))));
            text_q.push_back(hex_char(4'($urandom_range(0, 15))));
        end
        if ($urandom_range(0, 1))
        begin
            text_q.push_back(CH_SPACE);
            text_q.push_back(CH_SPACE);
            repeat ($urandom_range(1, 8)) text_q.push_back(CHAR_W'($urandom_range(8'h20, 8'h7E)));
        end
        if ($urandom_range(0, 1))
            text_q.push_back(CHAR_CR);
        text_q.push_back(CHAR_NL);
    endtask

    // Continuous hex pairs, occasional spaces, optional stray nibble and line end
    task automatic queue_plain_run();
        repeat ($urandom_range(1, 24))
        begin
            if ($urandom_range(0, 3) == 0)
                text_q.push_back(CH_SPACE);
            text_q.push_back(hex_char(4'($urandom_range(0, 15))));
            text_q.push_back(hex_char(4'($urandom_range(0, 15))));
        end
        if ($urandom_range(0, 5) == 0)
            text_q.push_back(hex_char(4'($urandom_range(0, 15))));
        if ($urandom_range(0, 2) == 0)
        begin
            if ($urandom_range(0, 1))
                text_q.push_back(CHAR_CR);
            text_q.push_back(CHAR_NL);
        end
    endtask

    // Mostly well-formed text with some noise mixed in
    task automatic run_random(input int n_chars, input bit plain_text, input int max_bytes);
        int sent;
        sent = 0;
        while (sent < n_chars)
        begin
            if ($urandom_range(0, 7) == 0)
                queue_noise($urandom_range(1, 6));
            else if (plain_text)
                queue_plain_run();
            else
                queue_offset_line($urandom_range(0, max_bytes));
            sent += text_q.size();
            send_text();
        end
    endtask

    // Main stimulus
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed text under reset settings: mixed case, CR, digit boundaries,
        // three non-hex in a row, extreme byte values while dropping a line
        queue_string("0: ff 00 aF 9F");
        text_q.push_back(CHAR_CR);
        text_q.push_back(CHAR_NL);
        queue_string("7:/:@G`g");
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        text_q.push_back(CHAR_NL);
        send_text();
        run_random(30, 1'b0, 18);
        settle();

        // One byte per line, largest positive base: addresses wrap
        write_reg(REG_COLUMNS, 32'd1);
        write_reg(REG_PLAIN_MODE, 32'd0);
        write_reg(REG_BASE_OFFSET, 32'h7FFF_FFFF);
        run_random(70, 1'b0, 3);
        settle();

        // Plain text, widest line; one long receiver hold-off lets the block fill up
        write_reg(REG_COLUMNS, 32'd256);
        write_reg(REG_PLAIN_MODE, 32'd1);
        write_reg(REG_BASE_OFFSET, 32'h0000_1000);
        hold_pending = 1'b1;
        run_random(70, 1'b1, 0);
        settle();

        // Zero columns acts as one
        write_reg(REG_COLUMNS, 32'd0);
        write_reg(REG_BASE_OFFSET, $urandom & 32'h7FFF_FFFF);
        run_random(40, 1'b1, 0);
        settle();

        // Columns above the maximum saturate
        write_reg(REG_COLUMNS, 32'h1FF);
        write_reg(REG_PLAIN_MODE, 32'd0);
        write_reg(REG_BASE_OFFSET, $urandom & 32'h0FFF_FFFF);
        run_random(40, 1'b0, 20);
        settle();

        // Last part without idling
        idle_enable = 1'b0;
        write_reg(REG_COLUMNS, 32'd8);
        write_reg(REG_BASE_OFFSET, 32'h0);
        run_random(40, 1'b0, 10);
        settle();

        // Negative base that the offset just covers
        write_reg(REG_BASE_OFFSET, 32'hFFFF_FF00);
        text_q.push_back(CHAR_NL);
        queue_string("100: 41 42");
        text_q.push_back(CHAR_NL);
        send_text();
        settle();

        // Most negative base: error beat, then halted for the rest of the run
        write_reg(REG_BASE_OFFSET, 32'h8000_0000);
        text_q.push_back(CHAR_NL);
        queue_string("0: 55 66");
        text_q.push_back(CHAR_NL);
        queue_string("0: 12 34");
        text_q.push_back(CHAR_NL);
        queue_noise(8);
        send_text();
        settle();

        repeat (DRAIN_PAD) @(posedge clk);
        if (mismatches == 0)
            $display("hexdump_text_to_binary_top_test: done, clean");
        else
            $display("hexdump_text_to_binary_top_test: done, errors");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/hdtb_pkg.sv
src/hdtb_front.sv
src/hdtb_queue.sv
src/hdtb_back.sv
src/hexdump_text_to_binary_top.sv
tb/sv/hexdump_text_to_binary_checker.sv
tb/sv/hexdump_text_to_binary_top_test.sv
